// ----- src/edt_pkg.sv -----
// ----------------------------------------------------------------------------
// edt_pkg
// Shared types, constants and helpers of the encoder detent and button tracker.
// ----------------------------------------------------------------------------
package edt_pkg;

	localparam int CHANNELS   = 8;
	localparam int COUNT_BITS = 32;
	localparam int FIELDS     = 8;
	localparam int DATA_W     = 32;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CPD_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int DIV_BITS   = 8;
	localparam int DIV_STEPS  = DATA_W / DIV_BITS;
	localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [DATA_W-1:0] CNT_MASK = DATA_W'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [CPD_W-1:0]  CPD_RESET = CPD_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_PRESENT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_DETENT = CFG_IDX_W'(1);

	localparam logic OP_POLL  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic              operation;
		logic signed [31:0] count_ch0;
		logic signed [31:0] count_ch1;
		logic signed [31:0] count_ch2;
		logic signed [31:0] count_ch3;
		logic signed [31:0] count_ch4;
		logic signed [31:0] count_ch5;
		logic signed [31:0] count_ch6;
		logic signed [31:0] count_ch7;
		logic [7:0]        button_levels;
		logic              switch_level;
		logic [7:0]        clear_mask;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] delta_ch0;
		logic signed [31:0] delta_ch1;
		logic signed [31:0] delta_ch2;
		logic signed [31:0] delta_ch3;
		logic signed [31:0] delta_ch4;
		logic signed [31:0] delta_ch5;
		logic signed [31:0] delta_ch6;
		logic signed [31:0] delta_ch7;
		logic [7:0]        pressed_mask;
		logic [7:0]        held_mask;
		logic              switch_state;
	} res_t;

	typedef struct packed {
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] resid;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [DATA_W-1:0] count_field(cmd_t c, logic [2:0] i);
		logic [DATA_W-1:0] v;
		case (i)
			3'd0: v = c.count_ch0;
			3'd1: v = c.count_ch1;
			3'd2: v = c.count_ch2;
			3'd3: v = c.count_ch3;
			3'd4: v = c.count_ch4;
			3'd5: v = c.count_ch5;
			3'd6: v = c.count_ch6;
			3'd7: v = c.count_ch7;
			default: v = '0;
		endcase
		return v & CNT_MASK;
	endfunction

	// Count difference wrapped to the counter width and sign extended.
	function automatic logic [DATA_W-1:0] wrap_diff(logic [DATA_W-1:0] cur,
			logic [DATA_W-1:0] prev);
		logic [DATA_W-1:0] d;
		d = (cur - prev) & CNT_MASK;
		if (d[COUNT_BITS-1]) begin
			d = d | ~CNT_MASK;
		end
		return d;
	endfunction

endpackage

// ----- src/edt_ram.sv -----
// ----------------------------------------------------------------------------
// edt_ram
// Simple dual-port synchronous RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module edt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/edt_div.sv -----
// ----------------------------------------------------------------------------
// edt_div
// Signed divider by a small unsigned divisor, truncating toward zero.
// Retires DIV_BITS quotient bits per cycle on the dividend magnitude.
// ----------------------------------------------------------------------------
module edt_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [edt_pkg::DATA_W-1:0]     dividend,
	input  logic [edt_pkg::CPD_W-1:0]      divisor,
	output logic                           done,
	output logic [edt_pkg::DATA_W-1:0]     quot,
	output logic [edt_pkg::DATA_W-1:0]     rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [edt_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           neg_q;
	logic [edt_pkg::CPD_W-1:0]      dvs_q;
	logic [edt_pkg::DATA_W-1:0]     mag_q;
	logic [edt_pkg::DATA_W-1:0]     quo_q;
	logic [edt_pkg::CPD_W-1:0]      rem_q;
	logic [edt_pkg::DATA_W-1:0]     mag_d;
	logic [edt_pkg::DATA_W-1:0]     quo_d;
	logic [edt_pkg::CPD_W-1:0]      rem_d;

	always_comb begin
		logic [edt_pkg::CPD_W:0] t;
		mag_d = mag_q;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int k = 0; k < edt_pkg::DIV_BITS; k++) begin
			t = {rem_d, mag_d[edt_pkg::DATA_W-1]};
			mag_d = {mag_d[edt_pkg::DATA_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				quo_d = {quo_d[edt_pkg::DATA_W-2:0], 1'b1};
			end else begin
				quo_d = {quo_d[edt_pkg::DATA_W-2:0], 1'b0};
			end
			rem_d = t[edt_pkg::CPD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + edt_pkg::DIV_CNT_W'(1);
				if (cnt_q == edt_pkg::DIV_CNT_W'(edt_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[edt_pkg::DATA_W-1];
			mag_q <= dividend[edt_pkg::DATA_W-1] ? -dividend : dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_d;
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -quo_q : quo_q;
	assign rem  = neg_q ? -(edt_pkg::DATA_W'(rem_q)) : edt_pkg::DATA_W'(rem_q);

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("Divider started while busy.");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("Divider done lasted more than one cycle.");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("Divider reported done while still busy.");
`endif

endmodule

// ----- src/encoder_detent_and_button_tracker_top.sv -----
// ----------------------------------------------------------------------------
// encoder_detent_and_button_tracker_top
// Tracks encoder detent steps per channel and latches button presses.
// ----------------------------------------------------------------------------
// A clear item or a poll while the device is absent goes straight to the done state and raises its result
// from there once the output is free. A baseline poll walks the channels with a memory read and a write back each.
// A later poll takes each channel through a memory read, an add, a divider start, four divider steps
// and the write back before its result is registered in the done state.
// One item is in flight at a time; the next can be taken in the cycle after the result is registered.
// Reset clears all state at once through per-channel valid bits; there is no clearing pass.
module encoder_detent_and_button_tracker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [edt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [edt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  edt_pkg::cmd_t                      cmd,
	output logic                               res_valid,
	input  logic                               res_stall,
	output edt_pkg::res_t                      res
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_CALC  = 6'b000100,
		ST_START = 6'b001000,
		ST_WAIT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                               state_q;
	logic                                 present_q;
	logic [edt_pkg::CPD_W-1:0]            cpd_q;
	logic                                 seeded_q;
	logic                                 base_q;
	logic                                 sw_q;
	logic [edt_pkg::CHANNELS-1:0]         btn_prev_q;
	logic [edt_pkg::CHANNELS-1:0]         held_q;
	logic [edt_pkg::CHANNELS-1:0]         press_q;
	logic [edt_pkg::CHANNELS-1:0]         vld_q;
	logic [edt_pkg::CH_W-1:0]             ch_q;
	logic [edt_pkg::DATA_W-1:0]           cnt_q [edt_pkg::CHANNELS];
	logic [edt_pkg::DATA_W-1:0]           delta_q [edt_pkg::CHANNELS];
	logic [edt_pkg::DATA_W-1:0]           sum_q;
	logic                                 res_valid_q;
	edt_pkg::res_t                        res_q;

	logic                                 accept;
	logic                                 last_ch;
	logic                                 out_free;
	logic [edt_pkg::CHANNELS-1:0]         lv;
	logic [edt_pkg::DATA_W-1:0]           cur;
	edt_pkg::entry_t                      rd_entry;
	edt_pkg::entry_t                      wr_entry;
	logic [edt_pkg::ENTRY_W-1:0]          ram_rdata;
	logic                                 ram_we;
	logic                                 ram_re;
	logic                                 div_start;
	logic                                 div_done;
	logic [edt_pkg::CPD_W-1:0]            div_divisor;
	logic [edt_pkg::DATA_W-1:0]           div_quot;
	logic [edt_pkg::DATA_W-1:0]           div_rem;
	logic [edt_pkg::DATA_W-1:0]           dlt [edt_pkg::FIELDS];
	edt_pkg::res_t                        res_d;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign last_ch   = (ch_q == edt_pkg::CH_W'(edt_pkg::CHANNELS - 1));
	assign out_free  = !res_valid_q || !res_stall;
	assign lv        = cmd.button_levels[edt_pkg::CHANNELS-1:0];
	assign cur       = cnt_q[ch_q];
	assign rd_entry  = vld_q[ch_q] ? edt_pkg::entry_t'(ram_rdata) : '0;

	assign ram_re    = (state_q == ST_READ);
	assign ram_we    = ((state_q == ST_CALC) && base_q) || ((state_q == ST_WAIT) && div_done);
	assign div_start = (state_q == ST_START);
	assign div_divisor = (cpd_q == '0) ? edt_pkg::CPD_W'(1) : cpd_q;

	always_comb begin
		wr_entry.prev  = cur;
		wr_entry.resid = (state_q == ST_CALC) ? rd_entry.resid : div_rem;
	end

	edt_ram #(
		.WIDTH(edt_pkg::ENTRY_W),
		.DEPTH(edt_pkg::CHANNELS),
		.AW   (edt_pkg::CH_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ch_q),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(ch_q),
		.rdata(ram_rdata)
	);

	edt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	always_comb begin
		for (int i = 0; i < edt_pkg::FIELDS; i++) begin
			dlt[i] = '0;
		end
		for (int i = 0; i < edt_pkg::CHANNELS; i++) begin
			dlt[i] = delta_q[i];
		end
		res_d.delta_ch0    = dlt[0];
		res_d.delta_ch1    = dlt[1];
		res_d.delta_ch2    = dlt[2];
		res_d.delta_ch3    = dlt[3];
		res_d.delta_ch4    = dlt[4];
		res_d.delta_ch5    = dlt[5];
		res_d.delta_ch6    = dlt[6];
		res_d.delta_ch7    = dlt[7];
		res_d.pressed_mask = 8'(press_q);
		res_d.held_mask    = 8'(held_q);
		res_d.switch_state = sw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= 1'b0;
			cpd_q       <= edt_pkg::CPD_RESET;
			seeded_q    <= 1'b0;
			base_q      <= 1'b0;
			sw_q        <= 1'b0;
			btn_prev_q  <= '0;
			held_q      <= '0;
			press_q     <= '0;
			vld_q       <= '0;
			ch_q        <= '0;
			res_valid_q <= 1'b0;
			delta_q     <= '{default: '0};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					edt_pkg::REG_DEVICE_PRESENT:    present_q <= cfg_data[0];
					edt_pkg::REG_COUNTS_PER_DETENT: cpd_q     <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						if (cmd.operation == edt_pkg::OP_CLEAR) begin
							press_q <= press_q & ~cmd.clear_mask[edt_pkg::CHANNELS-1:0];
							state_q <= ST_DONE;
						end else if (!present_q) begin
							state_q <= ST_DONE;
						end else if (!seeded_q) begin
							seeded_q   <= 1'b1;
							base_q     <= 1'b1;
							btn_prev_q <= lv;
							sw_q       <= cmd.switch_level;
							state_q    <= ST_READ;
						end else begin
							base_q     <= 1'b0;
							held_q     <= lv;
							press_q    <= press_q | (lv & ~btn_prev_q);
							btn_prev_q <= lv;
							sw_q       <= cmd.switch_level;
							state_q    <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (base_q) begin
						vld_q[ch_q] <= 1'b1;
						if (last_ch) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + edt_pkg::CH_W'(1);
							state_q <= ST_READ;
						end
					end else begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						vld_q[ch_q]   <= 1'b1;
						delta_q[ch_q] <= div_quot;
						if (last_ch) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + edt_pkg::CH_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < edt_pkg::CHANNELS; i++) begin
				cnt_q[i] <= edt_pkg::count_field(cmd, 3'(i));
			end
		end
		if (state_q == ST_CALC) begin
			sum_q <= rd_entry.resid + edt_pkg::wrap_diff(cur, rd_entry.prev);
		end
		if ((state_q == ST_DONE) && out_free) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_DONE))
		else $error("A result appeared without a finished item.");
	a_no_div_on_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> !base_q)
		else $error("Divider ran during a baseline poll.");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT))
		else $error("Divider finished outside the wait state.");
`endif

endmodule

// ----- sim/encoder_detent_and_button_tracker_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_detent_and_button_tracker_top_test
// Drives poll and clear items into the tracker under random idling on both
// sides and checks every report against a cycle-free model of the detent
// accumulators, press latches, held levels and switch state.
// ----------------------------------------------------------------------------
module encoder_detent_and_button_tracker_top_test;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 250;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [edt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [edt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           cmd_valid = 1'b0;
	logic                           cmd_stall;
	edt_pkg::cmd_t                  cmd = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	edt_pkg::res_t                  res;

	encoder_detent_and_button_tracker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #5 clk = ~clk;

	// Model state and configuration.
	logic        cfg_present;
	logic [4:0]  cfg_cpd;
	logic [31:0] tr_prev [8];
	logic [31:0] tr_resid [8];
	logic [31:0] tr_delta [8];
	logic [7:0]  tr_btn_prev;
	logic [7:0]  tr_held;
	logic [7:0]  tr_latch;
	logic        tr_switch;
	logic        tr_seeded;

	// Stimulus state: where each knob sits and what the buttons and switch read.
	logic [31:0] knob [8];
	logic [7:0]  btn_now;
	logic        sw_now;

	edt_pkg::cmd_t cmd_backlog [$];
	edt_pkg::res_t pending_reports [$];
	edt_pkg::res_t want;
	int   items_sent = 0;
	int   reports_seen = 0;
	int   fail_count = 0;
	int   hold_left = 0;
	int   quiet = 0;
	bit   steady = 1'b0;

	logic       present_plan [8] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
	logic [4:0] cpd_plan [8] = '{5'd2, 5'd1, 5'd16, 5'd0, 5'd9, 5'd31, 5'd3, 5'd7};

	function automatic edt_pkg::res_t step_tracker(edt_pkg::cmd_t c);
		edt_pkg::res_t r;
		logic [31:0] cnt [8];
		logic [7:0]  lv;
		longint      num;
		longint      quo;
		longint      rem;
		longint      dv;
		dv = (cfg_cpd == 5'd0) ? 64'sd1 : longint'(cfg_cpd);
		lv = c.button_levels;
		cnt[0] = c.count_ch0;
		cnt[1] = c.count_ch1;
		cnt[2] = c.count_ch2;
		cnt[3] = c.count_ch3;
		cnt[4] = c.count_ch4;
		cnt[5] = c.count_ch5;
		cnt[6] = c.count_ch6;
		cnt[7] = c.count_ch7;
		if (c.operation == edt_pkg::OP_CLEAR) begin
			tr_latch = tr_latch & ~c.clear_mask;
		end else if (cfg_present) begin
			if (!tr_seeded) begin
				tr_prev = cnt;
				tr_btn_prev = lv;
				tr_switch = c.switch_level;
				tr_seeded = 1'b1;
			end else begin
				for (int i = 0; i < 8; i++) begin
					tr_resid[i] = tr_resid[i] + (cnt[i] - tr_prev[i]);
					tr_prev[i] = cnt[i];
					num = longint'($signed(tr_resid[i]));
					quo = num / dv;
					rem = num - quo * dv;
					tr_delta[i] = quo[31:0];
					tr_resid[i] = rem[31:0];
				end
				tr_held = lv;
				tr_latch = tr_latch | (lv & ~tr_btn_prev);
				tr_btn_prev = lv;
				tr_switch = c.switch_level;
			end
		end
		r.delta_ch0 = tr_delta[0];
		r.delta_ch1 = tr_delta[1];
		r.delta_ch2 = tr_delta[2];
		r.delta_ch3 = tr_delta[3];
		r.delta_ch4 = tr_delta[4];
		r.delta_ch5 = tr_delta[5];
		r.delta_ch6 = tr_delta[6];
		r.delta_ch7 = tr_delta[7];
		r.pressed_mask = tr_latch;
		r.held_mask = tr_held;
		r.switch_state = tr_switch;
		return r;
	endfunction

	// Moves every knob by base + i * step, or sets it there when absolute.
	function automatic edt_pkg::cmd_t make_poll(bit absolute, logic [31:0] base,
			logic [31:0] step, logic [7:0] btns, logic sw);
		edt_pkg::cmd_t c;
		for (int i = 0; i < 8; i++) begin
			knob[i] = (absolute ? 32'd0 : knob[i]) + base + 32'(i) * step;
		end
		c = '0;
		c.operation = edt_pkg::OP_POLL;
		c.count_ch0 = knob[0];
		c.count_ch1 = knob[1];
		c.count_ch2 = knob[2];
		c.count_ch3 = knob[3];
		c.count_ch4 = knob[4];
		c.count_ch5 = knob[5];
		c.count_ch6 = knob[6];
		c.count_ch7 = knob[7];
		c.button_levels = btns;
		c.switch_level = sw;
		c.clear_mask = 8'($urandom);
		return c;
	endfunction

	function automatic edt_pkg::cmd_t make_clear(logic [7:0] mask);
		edt_pkg::cmd_t c;
		c.operation = edt_pkg::OP_CLEAR;
		c.count_ch0 = $urandom;
		c.count_ch1 = $urandom;
		c.count_ch2 = $urandom;
		c.count_ch3 = $urandom;
		c.count_ch4 = $urandom;
		c.count_ch5 = $urandom;
		c.count_ch6 = $urandom;
		c.count_ch7 = $urandom;
		c.button_levels = 8'($urandom);
		c.switch_level = 1'($urandom);
		c.clear_mask = mask;
		return c;
	endfunction

	// Mostly small turns of each knob, now and then a jump anywhere in range; some items are clears instead.
	function automatic edt_pkg::cmd_t random_item();
		if ($urandom_range(0, 99) < 12) begin
			return make_clear(8'($urandom));
		end
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				knob[i] = $urandom;
			end else begin
				knob[i] = knob[i] + ($urandom_range(0, 80) - 32'd40);
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			btn_now = btn_now ^ 8'($urandom);
		end
		if ($urandom_range(0, 4) == 0) begin
			sw_now = ~sw_now;
		end
		return make_poll(1'b0, 32'd0, 32'd0, btn_now, sw_now);
	endfunction

	task automatic wait_until_idle();
		while (cmd_backlog.size() != 0 || reports_seen < items_sent) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic present, logic [4:0] cpd);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= edt_pkg::REG_DEVICE_PRESENT;
		cfg_data <= edt_pkg::CFG_DATA_W'(present);
		@(posedge clk);
		cfg_index <= edt_pkg::REG_COUNTS_PER_DETENT;
		cfg_data <= cpd;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_present = present;
		cfg_cpd = cpd;
	endtask

	task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %h, actual %h", name, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				pending_reports.push_back(step_tracker(cmd));
			end
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
					cmd <= cmd_backlog.pop_front();
					items_sent++;
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				reports_seen++;
				if (pending_reports.size() == 0) begin
					$error("report arrived with no item waiting for it");
					fail_count++;
				end else begin
					want = pending_reports.pop_front();
					check_field("delta_ch0", want.delta_ch0, res.delta_ch0);
					check_field("delta_ch1", want.delta_ch1, res.delta_ch1);
					check_field("delta_ch2", want.delta_ch2, res.delta_ch2);
					check_field("delta_ch3", want.delta_ch3, res.delta_ch3);
					check_field("delta_ch4", want.delta_ch4, res.delta_ch4);
					check_field("delta_ch5", want.delta_ch5, res.delta_ch5);
					check_field("delta_ch6", want.delta_ch6, res.delta_ch6);
					check_field("delta_ch7", want.delta_ch7, res.delta_ch7);
					check_field("pressed_mask", 32'(want.pressed_mask),
						32'(res.pressed_mask));
					check_field("held_mask", 32'(want.held_mask), 32'(res.held_mask));
					check_field("switch_state", 32'(want.switch_state),
						32'(res.switch_state));
				end
				// Hold the output long enough that the block backs up into its input.
				if (reports_seen == 600) begin
					hold_left = 400;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !steady && ($urandom_range(0, 99) < 25);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		int p;
		cfg_present = 1'b0;
		cfg_cpd = edt_pkg::CPD_RESET;
		tr_prev = '{default: '0};
		tr_resid = '{default: '0};
		tr_delta = '{default: '0};
		tr_btn_prev = '0;
		tr_held = '0;
		tr_latch = '0;
		tr_switch = 1'b0;
		tr_seeded = 1'b0;
		knob = '{default: '0};
		btn_now = 8'($urandom);
		sw_now = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Device absent after reset: nothing is seeded, clears still act.
		cmd_backlog.push_back(make_poll(1'b1, 32'h0000_1234, 32'd7, 8'hFF, 1'b1));
		cmd_backlog.push_back(make_clear(8'hFF));
		wait_until_idle();

		// Baseline, then counts that wrap across the signed limits.
		configure(1'b1, 5'd1);
		cmd_backlog.push_back(make_poll(1'b1, 32'h7FFF_FFFF, 32'd0, 8'hAA, 1'b1));
		cmd_backlog.push_back(make_poll(1'b1, 32'h8000_0000, 32'd0, 8'h55, 1'b0));
		cmd_backlog.push_back(make_poll(1'b1, 32'h0000_0000, 32'h2000_0000, 8'hFF, 1'b1));
		cmd_backlog.push_back(make_poll(1'b1, 32'hFFFF_FFFF, 32'hE000_0000, 8'h00, 1'b0));
		cmd_backlog.push_back(make_clear(8'h0F));
		cmd_backlog.push_back(make_clear(8'h00));
		cmd_backlog.push_back(make_clear(8'hF0));
		wait_until_idle();

		// Remainders of both signs carried between polls.
		configure(1'b1, 5'd16);
		cmd_backlog.push_back(make_poll(1'b0, -32'sd17, 32'd5, 8'h0F, 1'b1));
		cmd_backlog.push_back(make_poll(1'b0, 32'd33, -32'sd9, 8'hF0, 1'b0));
		cmd_backlog.push_back(make_poll(1'b0, -32'sd1, 32'd0, 8'h3C, 1'b1));
		cmd_backlog.push_back(make_poll(1'b0, 32'd15, 32'd1, 8'hC3, 1'b0));
		wait_until_idle();

		// A detent size of zero divides by one.
		configure(1'b1, 5'd0);
		cmd_backlog.push_back(make_poll(1'b0, -32'sd3, 32'd1, 8'h00, 1'b1));
		wait_until_idle();

		configure(1'b1, 5'd31);
		cmd_backlog.push_back(make_poll(1'b0, -32'sd40, 32'd12, 8'hFF, 1'b0));
		cmd_backlog.push_back(make_poll(1'b0, 32'd7, -32'sd3, 8'h81, 1'b1));
		wait_until_idle();

		// Device removed after seeding: the poll is dropped, the clear is not.
		configure(1'b0, 5'd31);
		cmd_backlog.push_back(make_poll(1'b0, 32'd100, 32'd1, 8'h00, 1'b0));
		cmd_backlog.push_back(make_clear(8'h81));
		wait_until_idle();

		configure(1'b1, 5'd2);
		cmd_backlog.push_back(make_poll(1'b0, 32'd0, 32'd0, 8'hFF, 1'b1));
		wait_until_idle();

		for (p = 0; p < 8; p++) begin
			configure(present_plan[p], cpd_plan[p]);
			steady = (p == 2);
			repeat (PHASE_ITEMS) cmd_backlog.push_back(random_item());
			wait_until_idle();
		end
		steady = 1'b0;

		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_reports.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
